// ===== rtl/core/fea_pkg.sv =====
// ----------------------------------------------------------------------------
// fea_pkg - free extent allocator shared definitions
// Field widths, command and status codes, item and result structs, and the
// operand and flag groups of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package fea_pkg;

	localparam int MAX_EXTENTS_DEF = 64;
	localparam int MEM_BLOCKS      = 4096;
	localparam int BLOCK_KIB       = 4;
	localparam int KIB_BYTES       = 1 << 10;
	localparam int BLOCK_BYTES     = BLOCK_KIB * KIB_BYTES;
	localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
	localparam int ALLOC_CAP       = 4096;

	localparam int CMD_W    = 2;
	localparam int REQ_W    = 25;
	localparam int START_W  = 12;
	localparam int LEN_W    = 13;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int TOTAL_W  = 13;
	localparam int FIT_W    = 2;

	// blocks needed: request / block size rounded up
	localparam int NEED_W = REQ_W - BLOCK_SHIFT + 1;
	localparam int OP_W   = (NEED_W > LEN_W + 1) ? NEED_W : LEN_W + 1;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEFRAG = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd3;

	localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [REQ_W-1:0]   request_bytes;
		logic [START_W-1:0] extent_start;
		logic [LEN_W-1:0]   extent_blocks;
	} cmd_item_t;

	typedef struct packed {
		logic                ok;
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  granted_start;
		logic [LEN_W-1:0]    granted_blocks;
		logic [LEN_W-1:0]    min_free_blocks;
		logic [LEN_W-1:0]    max_free_blocks;
		logic [COUNT_W-1:0]  free_extent_count;
		logic [TOTAL_W-1:0]  allocation_total;
	} result_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} extent_t;

	typedef struct packed {
		logic [OP_W-1:0] a;
		logic [OP_W-1:0] b;
		logic [OP_W-1:0] c;
		logic [OP_W-1:0] d;
	} alu_ops_t;

	typedef struct packed {
		logic [OP_W-1:0] sum;
		logic [OP_W-1:0] diff;
		logic            a_lt_b;
		logic            a_eq_b;
		logic            c_lt_d;
	} alu_res_t;

endpackage

// ===== rtl/core/fea_extent_mem.sv =====
// ----------------------------------------------------------------------------
// fea_extent_mem - extent table storage
// One write port and one read port, read data registered. No reset: entries
// are only used once the valid bits say they were written.
// ----------------------------------------------------------------------------
module fea_extent_mem #(
	parameter int DEPTH = fea_pkg::MAX_EXTENTS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  fea_pkg::extent_t  wr_data,
	input  logic [IDX_W-1:0]  rd_addr,
	output fea_pkg::extent_t  rd_data
);

	fea_pkg::extent_t mem_q [DEPTH];
	fea_pkg::extent_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/fea_alu.sv =====
// ----------------------------------------------------------------------------
// fea_alu - shared add / subtract / compare unit
// Used by most steps of the sequencer: sum, difference with borrow, equality
// and a second magnitude compare for running min / max / best selection.
// ----------------------------------------------------------------------------
module fea_alu (
	input  fea_pkg::alu_ops_t ops,
	output fea_pkg::alu_res_t res
);

	localparam int OP_W = fea_pkg::OP_W;

	logic [OP_W:0] sub_w;

	always_comb begin
		sub_w      = {1'b0, ops.a} - {1'b0, ops.b};
		res.sum    = ops.a + ops.b;
		res.diff   = sub_w[OP_W-1:0];
		res.a_lt_b = sub_w[OP_W];	// borrow out
		res.a_eq_b = (ops.a == ops.b);
		res.c_lt_d = (ops.c < ops.d);
	end

endmodule

// ===== rtl/core/free_extent_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// free_extent_allocator_unit - free extent table with first/best/worst fit
// Sequencer, valid bits and statistics around the extent memory and the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
// Usage
//  Command channel: an item (cmd, request_bytes, extent_start, extent_blocks)
//  is taken at a rising edge with start high and busy low. busy stays high
//  until the result has been built.
//  Result channel: done pulses for exactly one cycle with the result item on
//  result. There is no back-pressure; the receiver must take it that cycle.
//  A new command may be started in the cycle done is high.
//  Configuration: fit_mode is written over cfg_valid / cfg_ready / cfg_data;
//  cfg_ready is high whenever the block is idle.
//  Command flow: each table walk steps one entry per cycle, and every scan
//  reads through the single memory read port:
//   allocate     fit scan, then statistics scan
//   insert       free slot search, then statistics scan
//   defragment   inner search per extent, then statistics scan
//   zero request / unknown command  statistics scan only
//  One command is in flight at a time.
//  Reset: valid bits cleared (table empty), allocation count zero, fit mode
//  best fit. The table memory itself is not cleared.
// ----------------------------------------------------------------------------
module free_extent_allocator_unit #(
	parameter int MAX_EXTENTS = fea_pkg::MAX_EXTENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fea_pkg::cmd_item_t          command,
	output logic                        done,
	output fea_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fea_pkg::FIT_W-1:0]   cfg_data
);

	localparam int IDX_W    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CNT_W    = $clog2(MAX_EXTENTS + 1);
	localparam int OP_W     = fea_pkg::OP_W;
	localparam int LEN_W    = fea_pkg::LEN_W;
	localparam int START_W  = fea_pkg::START_W;
	localparam int TOTAL_W  = fea_pkg::TOTAL_W;
	localparam int COUNT_W  = fea_pkg::COUNT_W;
	localparam int STATUS_W = fea_pkg::STATUS_W;
	localparam int FIT_W    = fea_pkg::FIT_W;
	localparam int SHIFT    = fea_pkg::BLOCK_SHIFT;

	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_EXTENTS - 1);
	localparam logic [OP_W-1:0]    MEM_OP    = OP_W'(fea_pkg::MEM_BLOCKS);
	localparam logic [LEN_W-1:0]   MEM_LEN   = LEN_W'(fea_pkg::MEM_BLOCKS);
	localparam logic [TOTAL_W-1:0] TOTAL_CAP = TOTAL_W'(fea_pkg::ALLOC_CAP);
	localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_EXTENTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NEED,			// blocks needed from the byte request
		S_FIT,			// fit scan over the table
		S_FIT_END,		// check the chosen extent, work out what remains
		S_ALLOC_WR,		// shrink or drop the chosen extent
		S_INS,			// lowest free slot search and write
		S_DF_OUTER,		// defragment: next valid extent
		S_DF_LOAD,		// defragment: latch extent, form its end
		S_DF_INNER,		// defragment: search for an extent starting at end
		S_DF_SUM,
		S_DF_WR,
		S_DF_NEXT,
		S_STAT,			// min / max / count scan
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [FIT_W-1:0]       fit_mode_q;
	fea_pkg::cmd_item_t     item_q;
	logic [OP_W-1:0]        need_q;

	// scan pipeline: address issued in one cycle, data seen in the next
	logic [IDX_W-1:0]       scan_q;
	logic                   issuing_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   last_s1;

	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	fea_pkg::extent_t       best_ext_q;
	logic [LEN_W-1:0]       rem_q;

	logic [IDX_W-1:0]       oi_q;
	logic [IDX_W-1:0]       j_q;
	fea_pkg::extent_t       cur_ext_q;
	logic [OP_W-1:0]        end_q;
	logic [LEN_W-1:0]       len_j_q;
	logic [OP_W-1:0]        sum_q;

	logic [LEN_W-1:0]       mn_q;
	logic [LEN_W-1:0]       mx_q;
	logic [CNT_W-1:0]       cnt_q;

	logic                   ok_q;
	logic [STATUS_W-1:0]    status_q;
	logic [START_W-1:0]     gstart_q;
	logic [LEN_W-1:0]       gblocks_q;
	logic [TOTAL_W-1:0]     granted_q;
	logic [MAX_EXTENTS-1:0] valid_q;

	logic                   done_q;
	fea_pkg::result_t       result_q;

	// memory and unit hookup
	logic                   mem_wr_en;
	logic [IDX_W-1:0]       mem_wr_addr;
	fea_pkg::extent_t       mem_wr_data;
	logic [IDX_W-1:0]       mem_rd_addr;
	fea_pkg::extent_t       rd_ext;
	fea_pkg::alu_ops_t      ops;
	fea_pkg::alu_res_t      alu;

	logic                   scan_st;
	logic                   mode_first;
	logic                   mode_worst;

	fea_extent_mem #(
		.DEPTH (MAX_EXTENTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_ext)
	);

	fea_alu u_alu (
		.ops (ops),
		.res (alu)
	);

	assign scan_st    = (state_q == S_FIT) || (state_q == S_DF_INNER) || (state_q == S_STAT);
	assign mode_first = (fit_mode_q == fea_pkg::FIT_FIRST);
	// mode three behaves as best fit
	assign mode_worst = (fit_mode_q == fea_pkg::FIT_WORST);

	// operand selection and memory port control per step
	always_comb begin
		ops         = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = oi_q;
		mem_wr_data = '0;
		mem_rd_addr = scan_q;
		unique case (state_q)
			S_NEED: begin
				ops.a = OP_W'(item_q.request_bytes >> SHIFT);
				ops.b = OP_W'(|item_q.request_bytes[SHIFT-1:0]);
			end
			S_FIT: begin
				ops.a = OP_W'(rd_ext.len);
				ops.b = need_q;
				if (mode_worst) begin
					ops.c = OP_W'(best_ext_q.len);
					ops.d = OP_W'(rd_ext.len);
				end else begin
					ops.c = OP_W'(rd_ext.len);
					ops.d = OP_W'(best_ext_q.len);
				end
			end
			S_FIT_END: begin
				ops.a = OP_W'(best_ext_q.len);
				ops.b = need_q;
			end
			S_ALLOC_WR: begin
				ops.a             = OP_W'(best_ext_q.start);
				ops.b             = need_q;
				mem_wr_en         = (rem_q != '0);
				mem_wr_addr       = best_idx_q;
				// start wraps: table covers a power-of-two block space
				mem_wr_data.start = alu.sum[START_W-1:0];
				mem_wr_data.len   = rem_q;
			end
			S_INS: begin
				ops.a             = MEM_OP;
				ops.b             = OP_W'(item_q.extent_blocks);
				mem_wr_en         = !valid_q[oi_q];
				mem_wr_addr       = oi_q;
				mem_wr_data.start = item_q.extent_start;
				mem_wr_data.len   = alu.a_lt_b ? MEM_LEN : item_q.extent_blocks;
			end
			S_DF_OUTER: begin
				mem_rd_addr = oi_q;
			end
			S_DF_LOAD: begin
				ops.a = OP_W'(rd_ext.start);
				ops.b = OP_W'(rd_ext.len);
			end
			S_DF_INNER: begin
				ops.a = OP_W'(rd_ext.start);
				ops.b = end_q;
			end
			S_DF_SUM: begin
				ops.a = OP_W'(cur_ext_q.len);
				ops.b = OP_W'(len_j_q);
			end
			S_DF_WR: begin
				ops.a             = MEM_OP;
				ops.b             = sum_q;
				mem_wr_en         = 1'b1;
				mem_wr_addr       = oi_q;
				mem_wr_data.start = cur_ext_q.start;
				mem_wr_data.len   = alu.a_lt_b ? MEM_LEN : sum_q[LEN_W-1:0];
			end
			S_STAT: begin
				ops.a = OP_W'(rd_ext.len);
				ops.b = OP_W'(mn_q);
				ops.c = OP_W'(mx_q);
				ops.d = OP_W'(rd_ext.len);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fit_mode_q <= fea_pkg::FIT_BEST;
			item_q     <= '0;
			need_q     <= '0;
			scan_q     <= '0;
			issuing_q  <= 1'b0;
			pend_s1    <= 1'b0;
			idx_s1     <= '0;
			last_s1    <= 1'b0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_ext_q <= '0;
			rem_q      <= '0;
			oi_q       <= '0;
			j_q        <= '0;
			cur_ext_q  <= '0;
			end_q      <= '0;
			len_j_q    <= '0;
			sum_q      <= '0;
			mn_q       <= '0;
			mx_q       <= '0;
			cnt_q      <= '0;
			ok_q       <= 1'b0;
			status_q   <= fea_pkg::ST_OK;
			gstart_q   <= '0;
			gblocks_q  <= '0;
			granted_q  <= '0;
			valid_q    <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				fit_mode_q <= cfg_data;
			end

			// scan pipeline advances in scan steps, is rearmed everywhere else
			if (scan_st) begin
				pend_s1 <= issuing_q;
				idx_s1  <= scan_q;
				last_s1 <= (scan_q == LAST_IDX);
				if (issuing_q) begin
					if (scan_q == LAST_IDX) begin
						issuing_q <= 1'b0;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
			end else begin
				scan_q    <= '0;
				issuing_q <= 1'b1;
				pend_s1   <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q    <= command;
						ok_q      <= 1'b0;
						status_q  <= fea_pkg::ST_OK;
						gstart_q  <= '0;
						gblocks_q <= '0;
						found_q   <= 1'b0;
						oi_q      <= '0;
						mn_q      <= '0;
						mx_q      <= '0;
						cnt_q     <= '0;
						unique case (command.cmd)
							fea_pkg::CMD_ALLOC: begin
								if (command.request_bytes == '0) begin
									status_q <= fea_pkg::ST_ZERO;
									state_q  <= S_STAT;
								end else begin
									state_q <= S_NEED;
								end
							end
							fea_pkg::CMD_INSERT: begin
								if (command.extent_blocks == '0) begin
									status_q <= fea_pkg::ST_ZERO;
									state_q  <= S_STAT;
								end else begin
									state_q <= S_INS;
								end
							end
							fea_pkg::CMD_DEFRAG: begin
								ok_q    <= 1'b1;
								state_q <= S_DF_OUTER;
							end
							default: begin
								// unknown command: report only
								state_q <= S_STAT;
							end
						endcase
					end
				end
				S_NEED: begin
					need_q  <= alu.sum;
					state_q <= S_FIT;
				end
				S_FIT: begin
					if (pend_s1) begin
						if (valid_q[idx_s1] &&
						    (mode_worst ? (!found_q || alu.c_lt_d) :
						     (!alu.a_lt_b && !found_q) ||
						     (!alu.a_lt_b && !mode_first && alu.c_lt_d))) begin
							found_q    <= 1'b1;
							best_idx_q <= idx_s1;
							best_ext_q <= rd_ext;
						end
						if (last_s1) begin
							state_q <= S_FIT_END;
						end
					end
				end
				S_FIT_END: begin
					// worst fit may have picked an extent that is too short
					if (!found_q || alu.a_lt_b) begin
						status_q <= fea_pkg::ST_NO_FIT;
						state_q  <= S_STAT;
					end else begin
						rem_q   <= alu.diff[LEN_W-1:0];
						state_q <= S_ALLOC_WR;
					end
				end
				S_ALLOC_WR: begin
					if (rem_q == '0) begin
						valid_q[best_idx_q] <= 1'b0;
					end
					gstart_q  <= best_ext_q.start;
					gblocks_q <= need_q[LEN_W-1:0];
					ok_q      <= 1'b1;
					if (granted_q != TOTAL_CAP) begin
						granted_q <= granted_q + 1'b1;
					end
					state_q <= S_STAT;
				end
				S_INS: begin
					if (!valid_q[oi_q]) begin
						valid_q[oi_q] <= 1'b1;
						ok_q          <= 1'b1;
						state_q       <= S_STAT;
					end else if (oi_q == LAST_IDX) begin
						status_q <= fea_pkg::ST_FULL;
						state_q  <= S_STAT;
					end else begin
						oi_q <= oi_q + 1'b1;
					end
				end
				S_DF_OUTER: begin
					if (valid_q[oi_q]) begin
						state_q <= S_DF_LOAD;
					end else if (oi_q == LAST_IDX) begin
						state_q <= S_STAT;
					end else begin
						oi_q <= oi_q + 1'b1;
					end
				end
				S_DF_LOAD: begin
					cur_ext_q <= rd_ext;
					end_q     <= alu.sum;
					state_q   <= S_DF_INNER;
				end
				S_DF_INNER: begin
					if (pend_s1) begin
						if (valid_q[idx_s1] && (idx_s1 != oi_q) && alu.a_eq_b) begin
							j_q     <= idx_s1;
							len_j_q <= rd_ext.len;
							state_q <= S_DF_SUM;
						end else if (last_s1) begin
							state_q <= S_DF_NEXT;
						end
					end
				end
				S_DF_SUM: begin
					sum_q   <= alu.sum;
					state_q <= S_DF_WR;
				end
				S_DF_WR: begin
					valid_q[j_q] <= 1'b0;
					state_q      <= S_DF_NEXT;
				end
				S_DF_NEXT: begin
					if (oi_q == LAST_IDX) begin
						state_q <= S_STAT;
					end else begin
						oi_q    <= oi_q + 1'b1;
						state_q <= S_DF_OUTER;
					end
				end
				S_STAT: begin
					if (pend_s1) begin
						if (valid_q[idx_s1]) begin
							if ((cnt_q == '0) || alu.a_lt_b) begin
								mn_q <= rd_ext.len;
							end
							if (alu.c_lt_d) begin
								mx_q <= rd_ext.len;
							end
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					result_q.ok                <= ok_q;
					result_q.status            <= status_q;
					result_q.granted_start     <= gstart_q;
					result_q.granted_blocks    <= gblocks_q;
					result_q.min_free_blocks   <= mn_q;
					result_q.max_free_blocks   <= mx_q;
					result_q.free_extent_count <= COUNT_W'(cnt_q);
					result_q.allocation_total  <= granted_q;
					done_q                     <= 1'b1;
					state_q                    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && (state_q == S_IDLE))
		else $error("result strobe while still working");

	a_alloc_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_WR) |-> valid_q[best_idx_q] && found_q)
		else $error("allocating from an invalid extent");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.ok |-> (result.granted_blocks == '0) &&
		(result.granted_start == '0))
		else $error("grant reported on a failed command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (cnt_q <= CNT_MAX))
		else $error("extent count beyond table size");

endmodule

// ===== verif/free_extent_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// free_extent_allocator_unit_tb - self-checking bench for the extent allocator
// A queue of commands and fit mode changes feeds a clocked driver. A shadow
// free table predicts every result, and a monitor checks each done pulse
// against the oldest prediction. Directed corner cases come first, then
// random phases under first, worst, spare and best fit.
// ----------------------------------------------------------------------------
module free_extent_allocator_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fea_pkg::*;

	localparam int SLOTS = MAX_EXTENTS_DEF;
	// spare codes, not named in the package
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [FIT_W-1:0] FIT_SPARE = 2'd3;
	// longest command is defragment: inner search per extent
	localparam int DEFRAG_CYCLES = SLOTS * (SLOTS + 6) + SLOTS + 4;
	localparam int SCAN_CYCLES = 2 * SLOTS + 8;
	localparam int REPORT_MAX = 10;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 110;

	typedef enum logic [1:0] {ACT_ITEM, ACT_SETTLE, ACT_FIT} act_kind_e;

	typedef struct {
		act_kind_e        kind;
		cmd_item_t        item;
		logic [FIT_W-1:0] fit;
		int unsigned      gap;
	} stim_act_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	cmd_item_t        command = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [FIT_W-1:0] cfg_data = FIT_BEST;

	// stimulus backlog and results still owed by the block
	stim_act_t   cmd_backlog[$];
	result_t     awaited_results[$];
	int unsigned cmds_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned fault_count = 0;
	int unsigned idle_spent = 0;
	longint unsigned run_budget = 0;
	longint unsigned cycle_limit = 64'hFFFF_FFFF;
	longint unsigned cycle_no = 0;

	// shadow free table; entries read only while live
	logic [START_W-1:0] shadow_start[SLOTS];
	logic [LEN_W-1:0]   shadow_len[SLOTS];
	bit                 shadow_live[SLOTS];
	int unsigned        grants_made = 0;
	logic [FIT_W-1:0]   fit_sel = FIT_BEST;

	free_extent_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one command to the shadow table and returns the result it owes.
	function automatic result_t apply_to_free_table(cmd_item_t c);
		result_t     r;
		int unsigned need;
		int unsigned tip;
		int unsigned sum;
		int          pick;
		int          hit;
		r = '0;
		case (c.cmd)
		CMD_ALLOC: begin
			if (c.request_bytes == 0) begin
				r.status = ST_ZERO;
			end else begin
				// bytes rounded up to whole blocks
				need = (c.request_bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
				pick = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!shadow_live[i])
						continue;
					// ties go to the lowest slot throughout
					case (fit_sel)
					FIT_FIRST: begin
						if (pick < 0 && shadow_len[i] >= need)
							pick = i;
					end
					FIT_WORST: begin
						if (pick < 0 || shadow_len[i] > shadow_len[pick])
							pick = i;
					end
					default: begin
						// best fit, spare mode too
						if (shadow_len[i] >= need &&
								(pick < 0 || shadow_len[i] < shadow_len[pick]))
							pick = i;
					end
					endcase
				end
				// worst fit: largest extent may still be too short
				if (pick >= 0 && shadow_len[pick] < need)
					pick = -1;
				if (pick < 0) begin
					r.status = ST_NO_FIT;
				end else begin
					r.ok = 1'b1;
					r.granted_start = shadow_start[pick];
					r.granted_blocks = need;
					shadow_len[pick] = shadow_len[pick] - need;
					if (shadow_len[pick] == 0)
						shadow_live[pick] = 1'b0;
					else
						shadow_start[pick] = (shadow_start[pick] + need) % MEM_BLOCKS;
					if (grants_made < ALLOC_CAP)
						grants_made++;
				end
			end
		end
		CMD_INSERT: begin
			if (c.extent_blocks == 0) begin
				r.status = ST_ZERO;
			end else begin
				hit = -1;
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && !shadow_live[i])
						hit = i;
				if (hit < 0) begin
					r.status = ST_FULL;
				end else begin
					shadow_start[hit] = c.extent_start;
					shadow_len[hit] = (c.extent_blocks > MEM_BLOCKS) ?
						MEM_BLOCKS : c.extent_blocks;
					shadow_live[hit] = 1'b1;
					r.ok = 1'b1;
				end
			end
		end
		CMD_DEFRAG: begin
			// one pass in slot order; a merged neighbour drops out of the pass
			for (int i = 0; i < SLOTS; i++) begin
				if (!shadow_live[i])
					continue;
				tip = shadow_start[i] + shadow_len[i];
				hit = -1;
				for (int j = 0; j < SLOTS; j++)
					if (hit < 0 && j != i && shadow_live[j] && shadow_start[j] == tip)
						hit = j;
				if (hit >= 0) begin
					sum = shadow_len[i] + shadow_len[hit];
					shadow_len[i] = (sum > MEM_BLOCKS) ? MEM_BLOCKS : sum;
					shadow_live[hit] = 1'b0;
				end
			end
			r.ok = 1'b1;
		end
		default: begin
		end
		endcase
		for (int i = 0; i < SLOTS; i++) begin
			if (!shadow_live[i])
				continue;
			if (r.free_extent_count == 0 || shadow_len[i] < r.min_free_blocks)
				r.min_free_blocks = shadow_len[i];
			if (shadow_len[i] > r.max_free_blocks)
				r.max_free_blocks = shadow_len[i];
			r.free_extent_count++;
		end
		r.allocation_total = grants_made;
		return r;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("ok %0d st %0d at %0d x%0d min %0d max %0d n %0d tot %0d",
			r.ok, r.status, r.granted_start, r.granted_blocks, r.min_free_blocks,
			r.max_free_blocks, r.free_extent_count, r.allocation_total);
	endfunction

	function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] op, int unsigned req,
			int unsigned xs, int unsigned xb);
		cmd_item_t c;
		c.cmd = op;
		c.request_bytes = req[REQ_W-1:0];
		c.extent_start = xs[START_W-1:0];
		c.extent_blocks = xb[LEN_W-1:0];
		return c;
	endfunction

	// Queues one command, with a random sender gap ahead of it when gaps is set.
	task automatic queue_item(input cmd_item_t it, input bit gaps);
		stim_act_t a;
		a.kind = ACT_ITEM;
		a.item = it;
		a.fit = FIT_BEST;
		a.gap = (gaps && $urandom_range(99) < 60) ? $urandom_range(160) : 0;
		cmd_backlog.push_back(a);
		run_budget += a.gap + ((it.cmd == CMD_DEFRAG) ? DEFRAG_CYCLES : SCAN_CYCLES);
	endtask

	// Fit mode is only changed with the block drained and idle.
	task automatic queue_fit_change(input logic [FIT_W-1:0] mode);
		stim_act_t a;
		a.item = '0;
		a.fit = mode;
		a.gap = 0;
		a.kind = ACT_SETTLE;
		cmd_backlog.push_back(a);
		a.kind = ACT_FIT;
		cmd_backlog.push_back(a);
		run_budget += SCAN_CYCLES;
	endtask

	// Runs of adjacent inserts, bursts of allocations, the odd defragment,
	// and some raw noise over full field widths.
	task automatic queue_random_phase(input int unsigned count, input bit gaps);
		int unsigned added;
		int unsigned kind;
		int unsigned run;
		int unsigned base;
		int unsigned blocks;
		int unsigned bytes;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				run = $urandom_range(2, 12);
				base = $urandom_range(MEM_BLOCKS - 1);
				repeat (run) begin
					blocks = ($urandom_range(19) == 0) ?
						$urandom_range(1, (1 << LEN_W) - 1) : $urandom_range(1, 64);
					queue_item(make_cmd(CMD_INSERT, 0, base, blocks), gaps);
					// now and then a duplicate start
					if ($urandom_range(9) != 0)
						base = (base + blocks) % MEM_BLOCKS;
				end
				added += run;
			end else if (kind < 75) begin
				run = $urandom_range(2, 12);
				repeat (run) begin
					case ($urandom_range(19))
					0:       bytes = $urandom_range(1, (1 << REQ_W) - 1);
					1:       bytes = $urandom_range(1, 64) * BLOCK_BYTES;
					default: bytes = $urandom_range(1, 64 * BLOCK_BYTES);
					endcase
					queue_item(make_cmd(CMD_ALLOC, bytes, 0, 0), gaps);
				end
				added += run;
			end else if (kind < 85) begin
				queue_item(make_cmd(CMD_DEFRAG, 0, 0, 0), gaps);
				added++;
			end else begin
				run = $urandom_range(1, 4);
				repeat (run) begin
					queue_item(make_cmd($urandom_range(CMD_SPARE),
						($urandom_range(9) < 3) ? 0 : $urandom,
						$urandom,
						($urandom_range(9) < 3) ? 0 : $urandom), gaps);
				end
				added += run;
			end
		end
	endtask

	// Driver: start and cfg_valid move only at the rising edge, one update each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			idle_spent = 0;
		end else begin : drive
			bit        took;
			bit        bus_free;
			logic      nxt_start;
			logic      nxt_cfg;
			stim_act_t act;
			took = start && !busy;
			bus_free = (!start || took) && (!cfg_valid || cfg_ready);
			nxt_start = 1'b0;
			nxt_cfg = 1'b0;
			if (took) begin
				awaited_results.push_back(apply_to_free_table(command));
				cmds_accepted++;
			end
			if (cfg_valid && cfg_ready)
				fit_sel = cfg_data;
			if (bus_free) begin
				if (cmd_backlog.size() != 0) begin
					act = cmd_backlog[0];
					case (act.kind)
					ACT_SETTLE: begin
						// hold off until every owed result has come back
						if (!took && !busy && results_seen == cmds_accepted)
							void'(cmd_backlog.pop_front());
					end
					ACT_FIT: begin
						void'(cmd_backlog.pop_front());
						nxt_cfg = 1'b1;
						cfg_data <= act.fit;
					end
					default: begin
						if (idle_spent < act.gap) begin
							idle_spent++;
						end else begin
							void'(cmd_backlog.pop_front());
							idle_spent = 0;
							nxt_start = 1'b1;
							command <= act.item;
						end
					end
					endcase
				end
				start <= nxt_start;
				cfg_valid <= nxt_cfg;
			end
		end
	end

	// Monitor: done marks the one cycle a result item is valid.
	always @(posedge clk) begin : check
		result_t want;
		if (arst_n && done) begin
			results_seen <= results_seen + 1;
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("result %0d arrived with none owed: %s", results_seen,
						describe(result));
			end else begin
				want = awaited_results.pop_front();
				if (result !== want) begin
					fault_count++;
					if (fault_count <= REPORT_MAX) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(result));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > cycle_limit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		logic [FIT_W-1:0] phase_fit;
		// empty table: no fit, zero sizes, spare command, defragment of nothing
		queue_item(make_cmd(CMD_ALLOC, 1, 0, 0), 1'b1);
		queue_item(make_cmd(CMD_ALLOC, 0, 0, 0), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 5, 0), 1'b1);
		queue_item(make_cmd(CMD_SPARE, (1 << REQ_W) - 1, MEM_BLOCKS - 1,
			(1 << LEN_W) - 1), 1'b1);
		queue_item(make_cmd(CMD_DEFRAG, 0, 0, 0), 1'b1);
		// oversized length saturates; full-size extents tie on best fit
		queue_item(make_cmd(CMD_INSERT, 0, MEM_BLOCKS - 1, (1 << LEN_W) - 1), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 0, MEM_BLOCKS), 1'b1);
		queue_item(make_cmd(CMD_ALLOC, MEM_BLOCKS * BLOCK_BYTES, 0, 0), 1'b1);
		queue_item(make_cmd(CMD_ALLOC, 1, 0, 0), 1'b1);
		// shrunken extent start wraps past the last block
		queue_item(make_cmd(CMD_INSERT, 0, MEM_BLOCKS - 2, 10), 1'b1);
		queue_item(make_cmd(CMD_ALLOC, 3 * BLOCK_BYTES, 0, 0), 1'b1);
		// adjacent chain with a duplicate start; a single pass merges once
		queue_item(make_cmd(CMD_INSERT, 0, 100, 5), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 105, 7), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 105, 3), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 112, 20), 1'b1);
		queue_item(make_cmd(CMD_DEFRAG, 0, 0, 0), 1'b1);
		// merge whose sum passes the memory size
		queue_item(make_cmd(CMD_INSERT, 0, 10, 4000), 1'b1);
		queue_item(make_cmd(CMD_INSERT, 0, 4010, 200), 1'b1);
		queue_item(make_cmd(CMD_DEFRAG, 0, 0, 0), 1'b1);
		// needs more blocks than memory holds, then one byte past a block
		queue_item(make_cmd(CMD_ALLOC, MEM_BLOCKS * BLOCK_BYTES + 1, 0, 0), 1'b1);
		queue_item(make_cmd(CMD_ALLOC, BLOCK_BYTES + 1, 0, 0), 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0:       phase_fit = FIT_FIRST;
			1:       phase_fit = FIT_WORST;
			2:       phase_fit = FIT_SPARE;
			3:       phase_fit = FIT_BEST;
			default: phase_fit = $urandom_range(FIT_SPARE);
			endcase
			queue_fit_change(phase_fit);
			if (p == 3) begin
				// flood to a full table, then drain it one block at a time
				repeat (SLOTS + 6)
					queue_item(make_cmd(CMD_INSERT, 0, $urandom_range(MEM_BLOCKS - 1), 1),
						1'b1);
				repeat (SLOTS + 6)
					queue_item(make_cmd(CMD_ALLOC, $urandom_range(1, BLOCK_BYTES), 0, 0),
						1'b1);
			end
			// phase five runs back to back with no sender gaps
			queue_random_phase(PHASE_ITEMS, p != 5);
		end
		cycle_limit = 4 * run_budget + 50000;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge, clear of the driver and monitor
		@(negedge clk);
		while (cmd_backlog.size() != 0 || start || results_seen != cmds_accepted)
			@(negedge clk);
		repeat (DEFRAG_CYCLES) @(negedge clk);

		if (fault_count == 0 && awaited_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
